>>> design/vmm_pkg.sv
// ----------------------------------------------------------------------------
// vmm_pkg
// Shared types and constants of the vector-matrix multiply engine: opcodes,
// register indexes, command format and queue status.
// ----------------------------------------------------------------------------
package vmm_pkg;

    // field widths
    localparam int OP_W   = 2;
    localparam int IDX_W  = 6;
    localparam int DATA_W = 32;
    localparam int LEN_W  = 7;
    localparam int CFG_W  = 1;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // request opcodes
    typedef enum logic [OP_W-1:0] {
        OP_MAT = 2'd0,
        OP_ROW = 2'd1,
        OP_RUN = 2'd2,
        OP_NOP = 2'd3
    } t_op;

    // configuration register indexes
    typedef enum logic [CFG_W-1:0] {
        CFG_INNER_LEN = 1'b0,
        CFG_OUT_LEN   = 1'b1
    } t_cfg_idx;

    // classified request as it travels through the queue
    typedef struct packed {
        t_op               op;
        logic [IDX_W-1:0]  k;
        logic [IDX_W-1:0]  j;
        logic [DATA_W-1:0] value;
    } t_cmd;

    // queue status seen by the front and the back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

>>> design/vmm_front.sv
// ----------------------------------------------------------------------------
// vmm_front
// Input stage: takes requests, drops those that have no effect and holds the
// rest in one register until the command queue has room.
// ----------------------------------------------------------------------------
module vmm_front #(
    parameter int MAX_INNER = 64,
    parameter int MAX_COLS  = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [vmm_pkg::OP_W-1:0]    i_opcode,
    input  logic [vmm_pkg::IDX_W-1:0]   i_row_index,
    input  logic [vmm_pkg::IDX_W-1:0]   i_col_index,
    input  logic signed [vmm_pkg::DATA_W-1:0] i_value,
    input  vmm_pkg::t_q_stat            i_q_stat,
    output logic                        o_push,
    output vmm_pkg::t_cmd               o_cmd
);

    logic          r_f_vld;
    vmm_pkg::t_cmd r_f_cmd;
    vmm_pkg::t_op  op;
    logic          k_ok;
    logic          j_ok;
    logic          keep;
    logic          accept;

    // range checks on write indexes
    assign op   = vmm_pkg::t_op'(i_opcode);
    assign k_ok = ({26'd0, i_row_index} < 32'(MAX_INNER));
    assign j_ok = ({26'd0, i_col_index} < 32'(MAX_COLS));

    // classify the request
    always_comb begin
        case (op)
            vmm_pkg::OP_MAT: keep = k_ok && j_ok;
            vmm_pkg::OP_ROW: keep = k_ok;
            vmm_pkg::OP_RUN: keep = 1'b1;
            default:         keep = 1'b0;
        endcase
    end

    // handshake
    assign o_in_stall = r_f_vld && i_q_stat.full;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push     = r_f_vld && !i_q_stat.full;
    assign o_cmd      = r_f_cmd;

    // holding register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else begin
            if (o_push) begin
                r_f_vld <= 1'b0;
            end
            if (accept && keep) begin
                r_f_vld <= 1'b1;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (accept && keep) begin
            r_f_cmd.op    <= op;
            r_f_cmd.k     <= i_row_index;
            r_f_cmd.j     <= i_col_index;
            r_f_cmd.value <= i_value;
        end
    end

endmodule

>>> design/vmm_queue.sv
// ----------------------------------------------------------------------------
// vmm_queue
// Short first-in first-out queue of classified commands between the front
// and the back.
// ----------------------------------------------------------------------------
module vmm_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  vmm_pkg::t_cmd     i_data,
    input  logic              i_pop,
    output vmm_pkg::t_cmd     o_data,
    output vmm_pkg::t_q_stat  o_stat
);

    vmm_pkg::t_cmd                 r_mem [vmm_pkg::QUEUE_DEPTH];
    logic [vmm_pkg::QPTR_W-1:0]    r_wr;
    logic [vmm_pkg::QPTR_W-1:0]    r_rd;
    logic [vmm_pkg::QPTR_W:0]      r_cnt;
    logic                          do_push;
    logic                          do_pop;

    assign o_stat.full  = (r_cnt == (vmm_pkg::QPTR_W+1)'(vmm_pkg::QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_data       = r_mem[r_rd];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

>>> design/vmm_back.sv
// ----------------------------------------------------------------------------
// vmm_back
// Execution side: performs element writes into the row and matrix memories
// and runs the dot products through one pipelined multiply-accumulate unit,
// one column at a time, into an output register.
// ----------------------------------------------------------------------------
module vmm_back #(
    parameter int MAX_INNER = 64,
    parameter int MAX_COLS  = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [vmm_pkg::LEN_W-1:0]          i_inner_len,
    input  logic [vmm_pkg::LEN_W-1:0]          i_out_len,
    input  vmm_pkg::t_cmd                      i_cmd,
    input  vmm_pkg::t_q_stat                   i_q_stat,
    output logic                               o_pop,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [vmm_pkg::IDX_W-1:0]          o_column,
    output logic signed [vmm_pkg::DATA_W-1:0]  o_result_value,
    output logic                               o_last
);

    localparam int ROWS  = (MAX_INNER < 64) ? MAX_INNER : 64;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam logic [vmm_pkg::LEN_W-1:0] ROWS_CAP = vmm_pkg::LEN_W'(ROWS);
    localparam logic [vmm_pkg::LEN_W-1:0] COLS_CAP = vmm_pkg::LEN_W'(MAX_COLS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_DRAIN
    } t_state;

    t_state                        r_state;
    t_state                        n_state;
    logic [vmm_pkg::LEN_W-1:0]     r_k;
    logic [vmm_pkg::LEN_W-1:0]     n_k;
    logic [vmm_pkg::LEN_W-1:0]     r_col;
    logic [vmm_pkg::LEN_W-1:0]     n_col;
    logic [vmm_pkg::LEN_W-1:0]     r_n;
    logic [vmm_pkg::LEN_W-1:0]     n_n;
    logic [vmm_pkg::LEN_W-1:0]     r_p;
    logic [vmm_pkg::LEN_W-1:0]     n_p;
    logic [vmm_pkg::LEN_W-1:0]     n_eff;
    logic [vmm_pkg::LEN_W-1:0]     p_eff;
    logic                          issue;
    logic                          mat_we;
    logic                          row_we;
    logic                          out_load;
    logic                          pipe_empty;

    logic [vmm_pkg::DATA_W-1:0]    r_mat_mem [ROWS][MAX_COLS];
    logic [vmm_pkg::DATA_W-1:0]    r_row_mem [ROWS];
    logic [vmm_pkg::DATA_W-1:0]    r_mat_rd;
    logic [vmm_pkg::DATA_W-1:0]    r_row_rd;
    logic [vmm_pkg::DATA_W-1:0]    r_prod;
    logic [vmm_pkg::DATA_W-1:0]    r_acc;
    logic                          r_s1_vld;
    logic                          r_s2_vld;

    logic                          r_out_vld;
    logic [vmm_pkg::IDX_W-1:0]     r_out_col;
    logic [vmm_pkg::DATA_W-1:0]    r_out_val;
    logic                          r_out_last;

    // effective lengths, clipped to the stored sizes
    assign n_eff = (i_inner_len > ROWS_CAP) ? ROWS_CAP : i_inner_len;
    assign p_eff = (i_out_len > COLS_CAP) ? COLS_CAP : i_out_len;
    assign pipe_empty = !r_s1_vld && !r_s2_vld;

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_k      = r_k;
        n_col    = r_col;
        n_n      = r_n;
        n_p      = r_p;
        issue    = 1'b0;
        o_pop    = 1'b0;
        mat_we   = 1'b0;
        row_we   = 1'b0;
        out_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop = 1'b1;
                    case (i_cmd.op)
                        vmm_pkg::OP_MAT: mat_we = 1'b1;
                        vmm_pkg::OP_ROW: row_we = 1'b1;
                        vmm_pkg::OP_RUN: begin
                            n_n   = n_eff;
                            n_p   = p_eff;
                            n_k   = '0;
                            n_col = '0;
                            if (p_eff != '0) begin
                                n_state = (n_eff == '0) ? S_DRAIN : S_ISSUE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_ISSUE: begin
                issue = 1'b1;
                n_k   = r_k + 7'd1;
                if (r_k + 7'd1 == r_n) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // column sum is final once the pipeline has emptied
                if (pipe_empty && (!r_out_vld || !i_out_stall)) begin
                    out_load = 1'b1;
                    n_k      = '0;
                    n_col    = r_col + 7'd1;
                    if (r_col + 7'd1 == r_p) begin
                        n_state = S_IDLE;
                    end else if (r_n == '0) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_state = S_ISSUE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state, pipeline control and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_k        <= '0;
            r_col      <= '0;
            r_n        <= '0;
            r_p        <= '0;
            r_s1_vld   <= 1'b0;
            r_s2_vld   <= 1'b0;
            r_acc      <= '0;
            r_out_vld  <= 1'b0;
            r_out_col  <= '0;
            r_out_val  <= '0;
            r_out_last <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_k      <= n_k;
            r_col    <= n_col;
            r_n      <= n_n;
            r_p      <= n_p;
            r_s1_vld <= issue;
            r_s2_vld <= r_s1_vld;
            if (out_load) begin
                r_acc <= '0;
            end else if (r_s2_vld) begin
                r_acc <= r_acc + r_prod;
            end
            if (out_load) begin
                r_out_vld  <= 1'b1;
                r_out_col  <= r_col[vmm_pkg::IDX_W-1:0];
                r_out_val  <= r_acc;
                r_out_last <= (r_col + 7'd1 == r_p);
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // row and matrix memories, registered reads
    always_ff @(posedge i_clk) begin
        if (mat_we) begin
            r_mat_mem[i_cmd.k[ROW_W-1:0]][i_cmd.j[COL_W-1:0]] <= i_cmd.value;
        end
        if (row_we) begin
            r_row_mem[i_cmd.k[ROW_W-1:0]] <= i_cmd.value;
        end
        if (issue) begin
            r_mat_rd <= r_mat_mem[r_k[ROW_W-1:0]][r_col[COL_W-1:0]];
            r_row_rd <= r_row_mem[r_k[ROW_W-1:0]];
        end
    end

    // product stage, low word only
    always_ff @(posedge i_clk) begin
        r_prod <= r_row_rd * r_mat_rd;
    end

    assign o_out_valid    = r_out_vld;
    assign o_column       = r_out_col;
    assign o_result_value = r_out_val;
    assign o_last         = r_out_last;

    // no product may be in flight once the sequencer is idle
    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> pipe_empty)
        else $error("pipeline busy while idle");

    // a column result is taken only after its last product was summed
    a_load_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_s1_vld && !r_s2_vld && (r_state == S_DRAIN)))
        else $error("result taken before accumulation finished");

    // inner index stays inside the requested length
    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ISSUE) |-> (r_k < r_n))
        else $error("inner index out of range");

    // emitted column stays inside the requested count
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (r_col < r_p))
        else $error("column index out of range");

    // the last flag closes a compute and returns the sequencer to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && (r_col + 7'd1 == r_p)) |=> (r_state == S_IDLE))
        else $error("sequencer kept running after last column");

endmodule

>>> design/vector_matrix_multiply.sv
// ----------------------------------------------------------------------------
// vector_matrix_multiply
// Integer row-vector times matrix engine with stored operands.
// ----------------------------------------------------------------------------
// Requests enter through a front stage and a four-entry command queue, so
// new requests keep flowing in while the engine works. An element write
// (opcode 0 or 1) is carried out by the engine and gives no result; opcode
// 3 and writes to indexes beyond the stored size are dropped at the front.
// A compute (opcode 2) runs one column at a time through a single pipelined
// multiply-accumulate unit: for each column it issues inner_len reads, lets
// the memory read and multiply stages drain, then loads the column sum into
// the output register, which an output stall can hold back. Results come in
// column order with o_last on the final one. inner_len is clipped to the
// smaller of MAX_INNER and 64, out_len to MAX_COLS; all arithmetic wraps
// modulo 2^32. Write configuration only while the engine is idle.
// ----------------------------------------------------------------------------
module vector_matrix_multiply #(
    parameter int MAX_INNER = 64,
    parameter int MAX_COLS  = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration
    input  logic                               i_cfg_we,
    input  logic [vmm_pkg::CFG_W-1:0]          i_cfg_index,
    input  logic [vmm_pkg::LEN_W-1:0]          i_cfg_data,
    // request channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [vmm_pkg::OP_W-1:0]           i_opcode,
    input  logic [vmm_pkg::IDX_W-1:0]          i_row_index,
    input  logic [vmm_pkg::IDX_W-1:0]          i_col_index,
    input  logic signed [vmm_pkg::DATA_W-1:0]  i_value,
    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [vmm_pkg::IDX_W-1:0]          o_column,
    output logic signed [vmm_pkg::DATA_W-1:0]  o_result_value,
    output logic                               o_last
);

    logic [vmm_pkg::LEN_W-1:0] r_inner_len;
    logic [vmm_pkg::LEN_W-1:0] r_out_len;
    logic                      push;
    logic                      pop;
    vmm_pkg::t_cmd             f_cmd;
    vmm_pkg::t_cmd             q_cmd;
    vmm_pkg::t_q_stat          q_stat;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inner_len <= 7'd64;
            r_out_len   <= 7'd64;
        end else if (i_cfg_we) begin
            case (vmm_pkg::t_cfg_idx'(i_cfg_index))
                vmm_pkg::CFG_INNER_LEN: r_inner_len <= i_cfg_data;
                vmm_pkg::CFG_OUT_LEN:   r_out_len   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // request intake
    vmm_front #(
        .MAX_INNER (MAX_INNER),
        .MAX_COLS  (MAX_COLS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_opcode    (i_opcode),
        .i_row_index (i_row_index),
        .i_col_index (i_col_index),
        .i_value     (i_value),
        .i_q_stat    (q_stat),
        .o_push      (push),
        .o_cmd       (f_cmd)
    );

    // command queue
    vmm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (f_cmd),
        .i_pop   (pop),
        .o_data  (q_cmd),
        .o_stat  (q_stat)
    );

    // execution engine
    vmm_back #(
        .MAX_INNER (MAX_INNER),
        .MAX_COLS  (MAX_COLS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_inner_len    (r_inner_len),
        .i_out_len      (r_out_len),
        .i_cmd          (q_cmd),
        .i_q_stat       (q_stat),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_column       (o_column),
        .o_result_value (o_result_value),
        .o_last         (o_last)
    );

endmodule
